@@ sv/llc_pkg.sv @@
`timescale 1ns / 1ps
package llc_pkg;

	localparam int CORDIC_STAGES = 28;
	localparam int TAB_LEN       = 41;
	localparam int NCELL         = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

	// datapath widths
	localparam int ANG_W = 31;   // wrapped angle, degrees q.20
	localparam int CW    = 44;   // cordic x, y, z in q.40
	localparam int IDX_W = 6;

	localparam logic signed [ANG_W-1:0] DEG360 = 31'sd377487360;
	localparam logic signed [ANG_W-1:0] DEG180 = 31'sd188743680;
	localparam logic signed [ANG_W-1:0] DEG90  = 31'sd94371840;

	localparam logic [36:0] RAD_PER_DEG = 37'd76760392275;
	localparam logic signed [CW-1:0] QUARTER_PI  = 44'sd863554413089;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 44'sd667681663043;

	// register indexes
	localparam logic REG_EARTH_RADIUS = 1'b0;
	localparam logic REG_GLOBE_SCALE  = 1'b1;

	localparam logic [39:0] EARTH_RADIUS_RST = 40'd6523904000;
	localparam logic [31:0] GLOBE_SCALE_RST  = 32'd6553600;

	// atan(2^-i) in q.40, alternating series summed in q.62
	function automatic logic signed [CW-1:0] atan_entry(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		int e;
		sum = 64'd0;
		if (i == 0) begin
			return QUARTER_PI;
		end
		for (k = 0; i * (2 * k + 1) <= 62; k++) begin
			e = 62 - i * (2 * k + 1);
			term = (64'd1 << e) / 64'(2 * k + 1);
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return CW'((sum + (64'd1 << 21)) >> 22);
	endfunction

endpackage

@@ sv/llc_in_if.sv @@
`timescale 1ns / 1ps
interface llc_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [28:0] longitude;
	logic signed [27:0] latitude;
	logic signed [39:0] height;

	modport source (output valid, func, longitude, latitude, height, input ready);
	modport sink (input valid, func, longitude, latitude, height, output ready);
endinterface

@@ sv/llc_out_if.sv @@
`timescale 1ns / 1ps
interface llc_out_if;
	logic               valid;
	logic               ready;
	logic signed [62:0] pos_x;
	logic signed [62:0] pos_y;
	logic signed [62:0] pos_z;
	logic               saturated;

	modport source (output valid, pos_x, pos_y, pos_z, saturated, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, saturated, output ready);
endinterface

@@ sv/llc_angle_prep.sv @@
`timescale 1ns / 1ps
module llc_angle_prep
	import llc_pkg::*;
(
	input  logic                    clk,
	input  logic                    en_s1,
	input  logic                    en_s2,
	input  logic signed [ANG_W-1:0] angle,
	output logic signed [CW-1:0]    z_s2,
	output logic                    flip_s2
);

	logic signed [ANG_W-1:0] wrap_a;
	logic signed [ANG_W-1:0] fold_a;
	logic                    fold_flip;
	logic [26:0]             mag_s1;
	logic                    neg_s1;
	logic                    flip_s1;
	logic [63:0]             prod;
	logic [CW-1:0]           zmag;

	// wrap into [-180, 180), then fold into [-90, 90]
	always_comb begin
		wrap_a = angle;
		if (wrap_a < 0) begin
			wrap_a = wrap_a + DEG360;
		end
		if (wrap_a >= DEG180) begin
			wrap_a = wrap_a - DEG360;
		end
		fold_a    = wrap_a;
		fold_flip = 1'b0;
		priority if (wrap_a > DEG90) begin
			fold_a    = wrap_a - DEG180;
			fold_flip = 1'b1;
		end else if (wrap_a < -DEG90) begin
			fold_a    = wrap_a + DEG180;
			fold_flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1  <= fold_a[ANG_W-1];
			mag_s1  <= fold_a[ANG_W-1] ? 27'(-fold_a) : 27'(fold_a);
			flip_s1 <= fold_flip;
		end
	end

	// degrees q.20 to radians q.40
	assign prod = 64'(mag_s1) * 64'(RAD_PER_DEG);
	assign zmag = CW'((prod + (64'd1 << 21)) >> 22);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			z_s2    <= neg_s1 ? -$signed(zmag) : $signed(zmag);
			flip_s2 <= flip_s1;
		end
	end

endmodule

@@ sv/llc_cordic_cell.sv @@
`timescale 1ns / 1ps
module llc_cordic_cell
	import llc_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [IDX_W-1:0]     idx,
	input  logic signed [CW-1:0] atan,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] z_in,
	output logic signed [CW-1:0] x_q,
	output logic signed [CW-1:0] y_q,
	output logic signed [CW-1:0] z_q
);

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	// arithmetic shift rounds toward minus infinity
	assign dx = y_in >>> idx;
	assign dy = x_in >>> idx;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[CW-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - atan;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + atan;
			end
		end
	end

endmodule

@@ sv/lonlat_height_to_cartesian.sv @@
`timescale 1ns / 1ps
// longitude / latitude / height to cartesian position on a sphere
//
// points: request channel with func, longitude, latitude (degrees q.20) and
// height (metres q.10). results: one request per point with pos_x, pos_y,
// pos_z and saturated. world mode (func 0) gives world cm q.16, unit mode
// (func 1) gives the direction scaled by 2^30.
// cfg_we / cfg_index / cfg_data write earth_radius (index 0) and
// globe_scale (index 1); write only while no point is in flight.
//
// the pipeline has two angle prep stages, one cordic cell per rotation
// (lon and lat run in two parallel rows) and five product stages.
// throughput is one point per cycle unless the row is full and the receiver
// stalls; every stage is a pipeline register. each stage moves when its
// successor moves or is empty, so a stalled receiver only freezes the tail;
// points are still taken while a bubble remains anywhere in the row.
// reset clears all valid bits and loads the register defaults.
module lonlat_height_to_cartesian
	import llc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	llc_in_if.sink       points,
	llc_out_if.source    results,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [39:0]  cfg_data
);

	localparam int D    = NCELL + 7;
	localparam int E1   = NCELL + 2;

	typedef struct packed {
		logic               func;
		logic signed [39:0] height;
		logic               flip_lon;
		logic               flip_lat;
	} sb_t;

	// config registers
	logic [39:0] earth_radius_q;
	logic [31:0] globe_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earth_radius_q <= EARTH_RADIUS_RST;
			globe_scale_q  <= GLOBE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EARTH_RADIUS: earth_radius_q <= cfg_data;
				REG_GLOBE_SCALE:  globe_scale_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// valid row with bubble collapsing
	logic [D-1:0] v_q;
	logic [D:0]   en;

	assign en[D] = results.ready;
	genvar k;
	generate
		for (k = 0; k < D; k++) begin : g_en
			assign en[k] = !v_q[k] || en[k+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en[k]) begin
					v_q[k] <= (k == 0) ? points.valid : v_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	endgenerate

	assign points.ready  = en[0];
	assign results.valid = v_q[D-1];

	// angle prep, stages 0 and 1
	logic signed [CW-1:0] zlon_s2;
	logic signed [CW-1:0] zlat_s2;
	logic                 flon_s2;
	logic                 flat_s2;
	logic                 func_s1, func_s2;
	logic signed [39:0]   height_s1, height_s2;

	llc_angle_prep u_prep_lon (
		.clk     (clk),
		.en_s1   (en[0]),
		.en_s2   (en[1]),
		.angle   (ANG_W'(points.longitude)),
		.z_s2    (zlon_s2),
		.flip_s2 (flon_s2)
	);

	llc_angle_prep u_prep_lat (
		.clk     (clk),
		.en_s1   (en[0]),
		.en_s2   (en[1]),
		.angle   (ANG_W'(points.latitude)),
		.z_s2    (zlat_s2),
		.flip_s2 (flat_s2)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			func_s1   <= points.func;
			height_s1 <= points.height;
		end
		if (en[1]) begin
			func_s2   <= func_s1;
			height_s2 <= height_s1;
		end
	end

	// cordic rows, one cell per rotation
	logic signed [CW-1:0] lx [NCELL+1];
	logic signed [CW-1:0] ly [NCELL+1];
	logic signed [CW-1:0] lz [NCELL+1];
	logic signed [CW-1:0] ax [NCELL+1];
	logic signed [CW-1:0] ay [NCELL+1];
	logic signed [CW-1:0] az [NCELL+1];
	sb_t                  sb_q [NCELL];

	assign lx[0] = CORDIC_GAIN;
	assign ly[0] = '0;
	assign lz[0] = zlon_s2;
	assign ax[0] = CORDIC_GAIN;
	assign ay[0] = '0;
	assign az[0] = zlat_s2;

	generate
		for (k = 0; k < NCELL; k++) begin : g_cell
			llc_cordic_cell u_lon (
				.clk (clk), .en (en[k+2]), .idx (IDX_W'(k)), .atan (atan_entry(k)),
				.x_in (lx[k]), .y_in (ly[k]), .z_in (lz[k]),
				.x_q (lx[k+1]), .y_q (ly[k+1]), .z_q (lz[k+1])
			);
			llc_cordic_cell u_lat (
				.clk (clk), .en (en[k+2]), .idx (IDX_W'(k)), .atan (atan_entry(k)),
				.x_in (ax[k]), .y_in (ay[k]), .z_in (az[k]),
				.x_q (ax[k+1]), .y_q (ay[k+1]), .z_q (az[k+1])
			);
			always_ff @(posedge clk) begin
				if (en[k+2]) begin
					if (k == 0) begin
						sb_q[k] <= '{func: func_s2, height: height_s2,
							flip_lon: flon_s2, flip_lat: flat_s2};
					end else begin
						sb_q[k] <= sb_q[(k == 0) ? 0 : k-1];
					end
				end
			end
		end
	endgenerate

	// e1: unfold, magnitudes and signs, radius
	logic signed [CW-1:0] clon, slon, clat, slat;
	logic signed [41:0]   rm;
	sb_t                  sb_e;
	logic [41:0]          acl_e1, aco_e1, asl_e1, aslat_e1;
	logic [2:0]           neg_e1;
	logic [40:0]          r_e1;
	logic                 rneg_e1, func_e1;

	assign sb_e = sb_q[NCELL-1];
	assign clon = sb_e.flip_lon ? -lx[NCELL] : lx[NCELL];
	assign slon = sb_e.flip_lon ? -ly[NCELL] : ly[NCELL];
	assign clat = sb_e.flip_lat ? -ax[NCELL] : ax[NCELL];
	assign slat = sb_e.flip_lat ? -ay[NCELL] : ay[NCELL];
	assign rm   = $signed({2'b00, earth_radius_q}) + 42'(sb_e.height);

	always_ff @(posedge clk) begin
		if (en[E1]) begin
			acl_e1   <= clat[CW-1] ? 42'(-clat) : 42'(clat);
			aco_e1   <= clon[CW-1] ? 42'(-clon) : 42'(clon);
			asl_e1   <= slon[CW-1] ? 42'(-slon) : 42'(slon);
			aslat_e1 <= slat[CW-1] ? 42'(-slat) : 42'(slat);
			neg_e1   <= {slat[CW-1], clat[CW-1] ^ slon[CW-1], clat[CW-1] ^ clon[CW-1]};
			r_e1     <= rm[41] ? 41'(-rm) : 41'(rm);
			rneg_e1  <= rm[41];
			func_e1  <= sb_e.func;
		end
	end

	// e2: partial products, 21 bit halves
	logic [41:0] c0hh_e2, c0hl_e2, c0lh_e2, c0ll_e2;
	logic [41:0] c1hh_e2, c1hl_e2, c1lh_e2, c1ll_e2;
	logic [51:0] rhg_e2;
	logic [52:0] rlg_e2;
	logic [41:0] aslat_e2;
	logic [2:0]  neg_e2;
	logic        rneg_e2, func_e2;

	always_ff @(posedge clk) begin
		if (en[E1+1]) begin
			c0hh_e2  <= 42'(acl_e1[41:21]) * 42'(aco_e1[41:21]);
			c0hl_e2  <= 42'(acl_e1[41:21]) * 42'(aco_e1[20:0]);
			c0lh_e2  <= 42'(acl_e1[20:0]) * 42'(aco_e1[41:21]);
			c0ll_e2  <= 42'(acl_e1[20:0]) * 42'(aco_e1[20:0]);
			c1hh_e2  <= 42'(acl_e1[41:21]) * 42'(asl_e1[41:21]);
			c1hl_e2  <= 42'(acl_e1[41:21]) * 42'(asl_e1[20:0]);
			c1lh_e2  <= 42'(acl_e1[20:0]) * 42'(asl_e1[41:21]);
			c1ll_e2  <= 42'(acl_e1[20:0]) * 42'(asl_e1[20:0]);
			rhg_e2   <= 52'(r_e1[40:21]) * 52'(globe_scale_q);
			rlg_e2   <= 53'(r_e1[20:0]) * 53'(globe_scale_q);
			aslat_e2 <= aslat_e1;
			neg_e2   <= neg_e1;
			rneg_e2  <= rneg_e1;
			func_e2  <= func_e1;
		end
	end

	// e3: sum partials, round direction to q.40
	logic [84:0]   p0, p1;
	logic [CW-1:0] mag_e3 [3];
	logic [72:0]   a_e3;
	logic [2:0]    neg_e3;
	logic          rneg_e3, func_e3;

	assign p0 = (85'(c0hh_e2) << 42) + (85'(c0hl_e2) << 21) + (85'(c0lh_e2) << 21)
		+ 85'(c0ll_e2) + (85'd1 << 39);
	assign p1 = (85'(c1hh_e2) << 42) + (85'(c1hl_e2) << 21) + (85'(c1lh_e2) << 21)
		+ 85'(c1ll_e2) + (85'd1 << 39);

	always_ff @(posedge clk) begin
		if (en[E1+2]) begin
			mag_e3[0] <= CW'(p0 >> 40);
			mag_e3[1] <= CW'(p1 >> 40);
			mag_e3[2] <= CW'(aslat_e2);
			a_e3      <= (73'(rhg_e2) << 21) + 73'(rlg_e2);
			neg_e3    <= neg_e2;
			rneg_e3   <= rneg_e2;
			func_e3   <= func_e2;
		end
	end

	// e4: radius times direction partials, unit rounding
	logic [74:0] a_pad;
	logic [46:0] pp_e4 [3][3][2];
	logic [34:0] u_e4 [3];
	logic [2:0]  neg_e4;
	logic        rneg_e4, func_e4;

	assign a_pad = 75'(a_e3);

	always_ff @(posedge clk) begin
		if (en[E1+3]) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					pp_e4[j][i][0] <= 47'(a_pad[25*i +: 25]) * 47'(mag_e3[j][21:0]);
					pp_e4[j][i][1] <= 47'(a_pad[25*i +: 25]) * 47'(mag_e3[j][43:22]);
				end
				u_e4[j] <= 35'((45'(mag_e3[j]) + 45'd512) >> 10);
			end
			neg_e4  <= neg_e3;
			rneg_e4 <= rneg_e3;
			func_e4 <= func_e3;
		end
	end

	// e5: round to q.16, clamp, sign, output register
	logic [118:0]       wp [3];
	logic [68:0]        wv [3];
	logic [68:0]        lim [3];
	logic [2:0]         wsat;
	logic signed [62:0] res [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			wp[j] = 119'd1 << 49;
			for (int i = 0; i < 3; i++) begin
				wp[j] = wp[j] + (119'(pp_e4[j][i][0]) << (25*i))
					+ (119'(pp_e4[j][i][1]) << (25*i + 22));
			end
			wv[j]   = 69'(wp[j] >> 50);
			lim[j]  = (rneg_e4 ^ neg_e4[j]) ? (69'd1 << 62) : ((69'd1 << 62) - 69'd1);
			wsat[j] = wv[j] > lim[j];
			if (wsat[j]) begin
				wv[j] = lim[j];
			end
			if (func_e4) begin
				res[j] = neg_e4[j] ? -$signed(63'(u_e4[j])) : $signed(63'(u_e4[j]));
			end else begin
				res[j] = (rneg_e4 ^ neg_e4[j]) ? -$signed(63'(wv[j])) : $signed(63'(wv[j]));
			end
		end
	end

	logic signed [62:0] px_e5, py_e5, pz_e5;
	logic               sat_e5, func_e5;

	always_ff @(posedge clk) begin
		if (en[E1+4]) begin
			px_e5   <= res[0];
			py_e5   <= res[1];
			pz_e5   <= res[2];
			sat_e5  <= !func_e4 && (|wsat);
			func_e5 <= func_e4;
		end
	end

	assign results.pos_x     = px_e5;
	assign results.pos_y     = py_e5;
	assign results.pos_z     = pz_e5;
	assign results.saturated = sat_e5;

`ifndef SYNTHESIS
	localparam logic signed [62:0] POS_LIM = 63'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [62:0] NEG_LIM = 63'sh4000_0000_0000_0000;

	// unit direction never clamps
	a_unit_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && func_e5 |-> !results.saturated)
		else $error("unit mode result flagged saturated");

	// a clamp leaves at least one axis at a limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.saturated |->
			(results.pos_x == POS_LIM || results.pos_x == NEG_LIM
			|| results.pos_y == POS_LIM || results.pos_y == NEG_LIM
			|| results.pos_z == POS_LIM || results.pos_z == NEG_LIM))
		else $error("saturated without a clamped axis");

	// a waiting result stays put until taken
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[D-1] && !results.ready |=> v_q[D-1] && $stable(px_e5) && $stable(sat_e5))
		else $error("output stage changed while stalled");
`endif

endmodule
